// File: hdl/dmat_pkg.sv
// dmat_pkg: shared types, codes and table helpers for the asid tlb
// no dependencies; imported by every module of the block
package dmat_pkg;

    localparam int unsigned SET_MAX_W = 12;

    localparam logic [2:0] REQ_LOOKUP    = 3'd0;
    localparam logic [2:0] REQ_INSERT    = 3'd1;
    localparam logic [2:0] REQ_FLUSH_VA  = 3'd2;
    localparam logic [2:0] REQ_FLUSH_CTX = 3'd3;
    localparam logic [2:0] REQ_FLUSH_ALL = 3'd4;

    localparam logic [2:0] TBL_DUR = 3'd0;
    localparam logic [2:0] TBL_DUW = 3'd1;
    localparam logic [2:0] TBL_DKR = 3'd2;
    localparam logic [2:0] TBL_DKW = 3'd3;
    localparam logic [2:0] TBL_IU  = 3'd4;
    localparam logic [2:0] TBL_IK  = 3'd5;
    localparam logic [2:0] TBL_IO  = 3'd6;
    localparam logic [2:0] TBL_MIX = 3'd7;

    localparam logic [2:0] GRP_DATA = 3'd0;
    localparam logic [2:0] GRP_INSN = 3'd1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  acc_kind;
        logic [31:0] virt_addr;
        logic [7:0]  asid;
        logic [31:0] phys_addr;
        logic        phys_is_io;
        logic        page_has_code;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic [31:0] phys_out;
    } t_out_word;

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_FLUSH,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        FM_ADDR_ONE,
        FM_ADDR_UPTO,
        FM_CTX,
        FM_ALL
    } t_fmode;

    typedef struct packed {
        t_op                  op;
        t_fmode               fmode;
        logic [2:0]           tbl;
        logic                 grp;
        logic                 insn;
        logic [31:0]          va;
        logic [31:0]          pa;
        logic [7:0]           ctx;
        logic [SET_MAX_W-1:0] set;
    } t_cmd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL1,
        F_MUL2,
        F_FIN
    } t_fstate;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_LK_RD,
        B_LK_CMP,
        B_IN_RDK,
        B_IN_RDU,
        B_IN_CHK,
        B_IN_WK,
        B_IN_WU,
        B_IN_WM,
        B_IN_WO,
        B_FLUSH,
        B_DONE
    } t_bstate;

    // table at position idx of a flush group
    function automatic logic [2:0] grp_table(input logic grp, input logic [2:0] idx);
        logic [2:0] tbl;
        tbl = TBL_DUR;
        if (grp) begin
            tbl = idx[0] ? TBL_IK : TBL_IU;
        end else begin
            case (idx)
                3'd0:    tbl = TBL_DUR;
                3'd1:    tbl = TBL_DUW;
                3'd2:    tbl = TBL_DKR;
                3'd3:    tbl = TBL_DKW;
                3'd4:    tbl = TBL_IO;
                default: tbl = TBL_MIX;
            endcase
        end
        return tbl;
    endfunction

    function automatic logic [2:0] grp_last(input logic grp);
        return grp ? 3'd1 : 3'd5;
    endfunction

endpackage

// File: hdl/dmat_front.sv
// dmat_front: accepts request words, reduces set and context, classifies
// depends on dmat_pkg
module dmat_front #(
    parameter int CONTEXTS   = 256,
    parameter int SETS       = 64,
    parameter int PAGE_SHIFT = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dmat_pkg::t_in_word i_word,
    output logic              o_push,
    input  logic              i_full,
    output dmat_pkg::t_cmd    o_cmd
);
    import dmat_pkg::*;

    localparam int X_W   = 32 - PAGE_SHIFT;
    localparam int CTX_W = $clog2(CONTEXTS);
    localparam logic [32:0] RECIP = 33'h1_0000_0000 / SETS;
    localparam logic [12:0] SETS_C = 13'(SETS);

    t_fstate             r_state, n_state;
    t_in_word            r_word;
    logic [X_W+32:0]     r_prod;
    logic [X_W:0]        r_qs;
    logic [X_W-1:0]      w_x;
    logic [X_W:0]        w_q;
    logic [X_W:0]        w_rem;
    logic [X_W:0]        w_set;
    logic [CTX_W-1:0]    w_ctx_tab [256];
    logic [CTX_W-1:0]    w_ctx;
    logic [CTX_W-1:0]    w_actx;
    t_cmd                w_cmd;

    assign w_x   = r_word.virt_addr[31:PAGE_SHIFT];
    assign w_q   = r_prod[X_W+32:32];
    assign w_rem = {1'b0, w_x} - r_qs;
    assign w_set = (w_rem >= (X_W+1)'(SETS_C)) ? w_rem - (X_W+1)'(SETS_C) : w_rem;

    // constant residue table for context reduction
    always_comb begin
        for (int k = 0; k < 256; k++) begin
            w_ctx_tab[k] = CTX_W'(k % CONTEXTS);
        end
    end

    assign w_ctx  = w_ctx_tab[r_word.asid];
    assign w_actx = w_ctx_tab[r_word.virt_addr[7:0]];

    always_comb begin
        w_cmd       = '0;
        w_cmd.op    = OP_NOP;
        w_cmd.fmode = FM_ALL;
        w_cmd.va    = r_word.virt_addr;
        w_cmd.pa    = r_word.phys_addr;
        w_cmd.ctx   = 8'(w_ctx);
        w_cmd.set   = SET_MAX_W'(w_set);
        w_cmd.tbl   = r_word.acc_kind;
        w_cmd.grp   = r_word.acc_kind[0];
        w_cmd.insn  = (r_word.acc_kind == TBL_IU) || (r_word.acc_kind == TBL_IK);
        case (r_word.req_type)
            REQ_LOOKUP: begin
                w_cmd.op = OP_LOOKUP;
            end
            REQ_INSERT: begin
                w_cmd.op = OP_INSERT;
                if (((r_word.acc_kind == TBL_DUW) || (r_word.acc_kind == TBL_DKW))
                        && r_word.page_has_code) begin
                    w_cmd.tbl = TBL_MIX;
                end
                if (r_word.phys_is_io) begin
                    w_cmd.tbl = TBL_IO;
                end
            end
            REQ_FLUSH_VA: begin
                w_cmd.ctx = 8'(w_actx);
                w_cmd.fmode = (w_actx == '0) ? FM_ADDR_UPTO : FM_ADDR_ONE;
                if ((r_word.acc_kind == GRP_DATA) || (r_word.acc_kind == GRP_INSN)) begin
                    w_cmd.op = OP_FLUSH;
                end
            end
            REQ_FLUSH_CTX: begin
                w_cmd.fmode = FM_CTX;
                if ((r_word.acc_kind == GRP_DATA) || (r_word.acc_kind == GRP_INSN)) begin
                    w_cmd.op = OP_FLUSH;
                end
            end
            REQ_FLUSH_ALL: begin
                w_cmd.fmode = FM_ALL;
                if ((r_word.acc_kind == GRP_DATA) || (r_word.acc_kind == GRP_INSN)) begin
                    w_cmd.op = OP_FLUSH;
                end
            end
            default: begin
                w_cmd.op = OP_NOP;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_valid) n_state = F_MUL1;
            F_MUL1:  n_state = F_MUL2;
            F_MUL2:  n_state = F_FIN;
            F_FIN:   if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == F_IDLE);
        o_push  = (r_state == F_FIN) && !i_full;
        o_cmd   = w_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == F_IDLE) && i_valid) begin
            r_word <= i_word;
        end
        if (r_state == F_MUL1) begin
            r_prod <= (X_W+33)'(w_x) * (X_W+33)'(RECIP);
        end
        if (r_state == F_MUL2) begin
            r_qs <= w_q * (X_W+1)'(SETS_C);
        end
    end

endmodule

// File: hdl/dmat_fifo.sv
// dmat_fifo: two-entry command queue between front and back
// depends on dmat_pkg
module dmat_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dmat_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dmat_pkg::t_cmd o_cmd
);
    import dmat_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// File: hdl/dmat_back.sv
// dmat_back: entry memory, lookup/insert/flush sequencer, result register
// depends on dmat_pkg
module dmat_back #(
    parameter int CONTEXTS = 256,
    parameter int SETS     = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  dmat_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output dmat_pkg::t_out_word o_word
);
    import dmat_pkg::*;

    localparam int CTX_W = $clog2(CONTEXTS);
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int AW    = 3 + CTX_W + SET_W;
    localparam logic [CTX_W-1:0] CTX_TOP = CTX_W'(CONTEXTS - 1);
    localparam logic [SET_W-1:0] SET_TOP = SET_W'(SETS - 1);

    // entry: valid, virtual address, physical word
    logic [64:0]       r_mem [2**AW];
    logic [64:0]       r_rd;

    t_bstate           r_state, n_state;
    t_cmd              r_cmd;
    logic [AW-1:0]     r_clr;
    logic [CTX_W-1:0]  r_hi_ctx;
    logic              r_k_hit, r_u_hit;
    logic [2:0]        r_ti;
    logic [CTX_W-1:0]  r_c, r_lo, r_hi;
    logic [SET_W-1:0]  r_s;
    logic              r_all_sets;
    logic              r_res_hit;
    logic [31:0]       r_res_phys;
    logic              r_out_valid;
    t_out_word         r_out;

    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [64:0]       w_wdata;
    logic [CTX_W-1:0]  w_ctx;
    logic [SET_W-1:0]  w_set;
    logic              w_match;
    logic              w_load;
    logic              w_sweep_end;

    assign w_ctx   = r_cmd.ctx[CTX_W-1:0];
    assign w_set   = r_cmd.set[SET_W-1:0];
    assign w_match = r_rd[64] && (r_rd[63:32] == r_cmd.va) && (r_rd[31:0] == r_cmd.pa);
    assign w_load  = (r_state == B_DONE) && (!r_out_valid || i_ready);
    assign w_sweep_end = (!r_all_sets || (r_s == SET_TOP)) && (r_c == r_hi)
                       && (r_ti == grp_last(r_cmd.grp));

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR: if (r_clr == '1) n_state = B_IDLE;
            B_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.op)
                        OP_LOOKUP: n_state = B_LK_RD;
                        OP_INSERT: n_state = i_cmd.insn ? B_IN_RDK : B_IN_WO;
                        OP_FLUSH:  n_state = B_FLUSH;
                        default:   n_state = B_DONE;
                    endcase
                end
            end
            B_LK_RD:  n_state = B_LK_CMP;
            B_LK_CMP: n_state = B_DONE;
            B_IN_RDK: n_state = B_IN_RDU;
            B_IN_RDU: n_state = B_IN_CHK;
            B_IN_CHK: n_state = B_IN_WK;
            B_IN_WK:  n_state = B_IN_WU;
            B_IN_WU:  n_state = B_IN_WM;
            B_IN_WM:  n_state = B_IN_WO;
            B_IN_WO:  n_state = B_DONE;
            B_FLUSH:  if (w_sweep_end) n_state = B_DONE;
            B_DONE:   if (w_load) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = (r_state == B_IDLE) && !i_empty;
        w_we    = 1'b0;
        w_waddr = {TBL_MIX, w_ctx, w_set};
        w_wdata = {1'b1, r_cmd.va, r_cmd.pa};
        w_raddr = {r_cmd.tbl, w_ctx, w_set};
        case (r_state)
            B_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            B_IN_RDK: w_raddr = {TBL_DKW, w_ctx, w_set};
            B_IN_RDU: w_raddr = {TBL_DUW, w_ctx, w_set};
            B_IN_WK: begin
                w_we    = r_k_hit;
                w_waddr = {TBL_DKW, w_ctx, w_set};
                w_wdata = '0;
            end
            B_IN_WU: begin
                w_we    = r_u_hit;
                w_waddr = {TBL_DUW, w_ctx, w_set};
                w_wdata = '0;
            end
            B_IN_WM: w_we = r_k_hit || r_u_hit;
            B_IN_WO: begin
                w_we    = 1'b1;
                w_waddr = {r_cmd.tbl, w_ctx, w_set};
            end
            B_FLUSH: begin
                w_we    = 1'b1;
                w_waddr = {grp_table(r_cmd.grp, r_ti), r_c, r_s};
                w_wdata = '0;
            end
            default: w_we = 1'b0;
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_hi_ctx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) r_clr <= r_clr + 1'b1;
            if ((r_state == B_IN_WO) && (w_ctx > r_hi_ctx)) r_hi_ctx <= w_ctx;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd      <= i_cmd;
            r_res_hit  <= 1'b0;
            r_res_phys <= '0;
            r_ti       <= '0;
            r_all_sets <= (i_cmd.fmode == FM_CTX) || (i_cmd.fmode == FM_ALL);
            r_s        <= ((i_cmd.fmode == FM_CTX) || (i_cmd.fmode == FM_ALL))
                          ? '0 : i_cmd.set[SET_W-1:0];
            case (i_cmd.fmode)
                FM_ADDR_ONE, FM_CTX: begin
                    r_lo <= i_cmd.ctx[CTX_W-1:0];
                    r_c  <= i_cmd.ctx[CTX_W-1:0];
                    r_hi <= i_cmd.ctx[CTX_W-1:0];
                end
                FM_ADDR_UPTO: begin
                    r_lo <= '0;
                    r_c  <= '0;
                    r_hi <= r_hi_ctx;
                end
                default: begin
                    r_lo <= '0;
                    r_c  <= '0;
                    r_hi <= CTX_TOP;
                end
            endcase
        end
        if ((r_state == B_LK_CMP) && r_rd[64] && (r_rd[63:32] == r_cmd.va)) begin
            r_res_hit  <= 1'b1;
            r_res_phys <= r_rd[31:0];
        end
        if (r_state == B_IN_RDU) r_k_hit <= w_match;
        if (r_state == B_IN_CHK) r_u_hit <= w_match;
        // sweep: set, then context, then table of the group
        if (r_state == B_FLUSH) begin
            if (r_all_sets && (r_s != SET_TOP)) begin
                r_s <= r_s + 1'b1;
            end else begin
                if (r_all_sets) r_s <= '0;
                if (r_c != r_hi) begin
                    r_c <= r_c + 1'b1;
                end else begin
                    r_c  <= r_lo;
                    r_ti <= r_ti + 1'b1;
                end
            end
        end
        if (w_load) begin
            r_out.hit      <= r_res_hit;
            r_out.phys_out <= r_res_phys;
        end
    end

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_CLEAR) |-> !o_pop)
        else $error("command taken during clearing pass");

    a_no_write_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == B_LK_RD) || (r_state == B_LK_CMP)) |-> !w_we)
        else $error("memory written during lookup");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == B_DONE))
        else $error("result raised outside done state");

    a_hi_ctx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hi_ctx <= CTX_TOP)
        else $error("highest context out of range");

endmodule

// File: hdl/direct_mapped_asid_tlb.sv
// direct_mapped_asid_tlb: a lookup passes the front (capture, two multiply steps, finish),
// the queue and the back (read, compare, done); the front takes no new word until it has
// pushed the last (two-multiply set reduction); flushes one memory write per cleared entry.
// reset: synchronous active low; then a clearing pass over 2**(3+clog2(CONTEXTS)+
// clog2(SETS)) entries (131072 by default) during which no request is executed.
// depends on dmat_pkg, dmat_front, dmat_fifo, dmat_back
module direct_mapped_asid_tlb #(
    parameter int CONTEXTS   = 256,
    parameter int SETS       = 64,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dmat_pkg::t_in_word  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dmat_pkg::t_out_word o_out
);
    import dmat_pkg::*;

    // front to queue
    logic  w_push, w_full;
    t_cmd  w_fcmd;
    // queue to back
    logic  w_pop, w_empty;
    t_cmd  w_qcmd;

    // front: takes a word, reduces the page number modulo SETS and the context
    // modulo CONTEXTS, picks the target table for inserts
    dmat_front #(
        .CONTEXTS   (CONTEXTS),
        .SETS       (SETS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_cmd   (w_fcmd)
    );

    // short queue so the front keeps working while a flush sweeps
    dmat_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_fcmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_qcmd)
    );

    // back: owns the entry memory and the result register
    dmat_back #(
        .CONTEXTS (CONTEXTS),
        .SETS     (SETS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_qcmd),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out)
    );

endmodule
